### hdl/tpct_pkg.sv
// Shared types, codes and constants of the two-phase countdown timer.
package tpct_pkg;

  // Payload widths
  localparam int unsigned MODE_W = 3;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned SEC_W  = 16;
  localparam int unsigned MIN_W  = 11;
  localparam int unsigned SS_W   = 6;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CIDX_W = 2;

  // Shared divider geometry
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned DVS_W  = 20;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
  // remaining * 100 needs this many bits
  localparam int unsigned P100_W = SEC_W + 7;

  // Reset values and defaults
  localparam logic [SEC_W-1:0] WORK_RESET         = SEC_W'(1500);
  localparam logic [SEC_W-1:0] BREAK_RESET        = SEC_W'(300);
  localparam int unsigned      MS_PER_SECOND_DEF  = 1000;
  localparam logic [DVS_W-1:0] SECS_PER_MIN       = DVS_W'(60);
  localparam logic [PCT_W-1:0] PCT_FULL           = PCT_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_START     = 3'd1,
    MODE_STOP      = 3'd2,
    MODE_RESET     = 3'd3,
    MODE_SEL_WORK  = 3'd4,
    MODE_SEL_BREAK = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CHIME_NONE    = 2'd0,
    CHIME_CLICK   = 2'd1,
    CHIME_SUCCESS = 2'd2
  } chime_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WORK  = 2'd0,
    CFG_BREAK = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC_RUN,
    ST_MIN_GO,
    ST_MIN_RUN,
    ST_PCT_GO,
    ST_PCT_RUN,
    ST_HOLD
  } ctl_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TS_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic             phase;
    logic             running;
    logic [MIN_W-1:0] minutes_left;
    logic [SS_W-1:0]  seconds_left;
    logic [PCT_W-1:0] percent_left;
    logic [1:0]       chime;
  } out_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [SEC_W-1:0]  data;
  } cfg_item_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

### hdl/tpct_chan_if.sv
// Valid/ready channel carrying one payload item.
interface tpct_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/tpct_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tpct_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpct_pkg::div_req_t  req_i,
  output tpct_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DIV_W = tpct_pkg::DIV_W;
  localparam int unsigned DVS_W = tpct_pkg::DVS_W;
  localparam int unsigned CNT_W = tpct_pkg::CNT_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem_q, acc_q[DIV_W-1]} - {2'b00, dvs_q};
  assign ge   = ~diff[DVS_W+1];

  // Load on start, shift one bit while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.len;
      acc_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      acc_d = {acc_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : {rem_q[DVS_W-2:0], acc_q[DIV_W-1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;
  assign rsp_o.rem  = rem_q;

  // The last step always ends the run with a done pulse
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == CNT_W'(1)) |=> (done_q && !busy_q))
    else $error("divider did not finish after its last step");

endmodule

### hdl/tpct_ctrl.sv
// Timer state and command sequencer that drives the shared divider.
module tpct_ctrl #(
  parameter int unsigned MS_PER_SECOND = tpct_pkg::MS_PER_SECOND_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tpct_chan_if.sink                     in_i,
  input  logic [tpct_pkg::SEC_W-1:0]    work_secs_i,
  input  logic [tpct_pkg::SEC_W-1:0]    break_secs_i,
  output tpct_pkg::div_req_t            div_req_o,
  input  tpct_pkg::div_rsp_t            div_rsp_i,
  output logic                          res_valid_o,
  output tpct_pkg::out_item_t           res_o,
  input  logic                          res_take_i
);

  localparam int unsigned TS_W   = tpct_pkg::TS_W;
  localparam int unsigned SEC_W  = tpct_pkg::SEC_W;
  localparam int unsigned DIV_W  = tpct_pkg::DIV_W;
  localparam int unsigned DVS_W  = tpct_pkg::DVS_W;
  localparam int unsigned CNT_W  = tpct_pkg::CNT_W;
  localparam int unsigned P100_W = tpct_pkg::P100_W;
  localparam int unsigned MIN_W  = tpct_pkg::MIN_W;
  localparam int unsigned SS_W   = tpct_pkg::SS_W;
  localparam int unsigned PCT_W  = tpct_pkg::PCT_W;
  localparam logic [DVS_W-1:0] MsDiv = DVS_W'(MS_PER_SECOND);

  tpct_pkg::ctl_state_e state_q, state_d;

  logic             phase_q, phase_d;
  logic             run_q, run_d;
  logic [SEC_W-1:0] len_q, len_d;
  logic [SEC_W-1:0] rem_q, rem_d;
  logic [TS_W-1:0]  ref_q, ref_d;
  logic             refv_q, refv_d;
  logic [TS_W-1:0]  now_q, now_d;
  logic [1:0]       chime_q, chime_d;
  logic [MIN_W-1:0] mins_q, mins_d;
  logic [SS_W-1:0]  ss_q, ss_d;
  logic [PCT_W-1:0] pct_q, pct_d;

  logic             accept;
  logic             measure;
  logic [P100_W-1:0] rem100;
  logic [DIV_W-1:0]  secs;
  tpct_pkg::mode_e   mode;

  assign mode    = tpct_pkg::mode_e'(in_i.data.mode);
  assign accept  = in_i.valid && in_i.ready;
  assign measure = (mode == tpct_pkg::MODE_TICK) && run_q && refv_q;
  assign rem100  = (P100_W'(rem_q) << 6) + (P100_W'(rem_q) << 5) + (P100_W'(rem_q) << 2);
  assign secs    = div_rsp_i.quot;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpct_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = measure ? tpct_pkg::ST_SEC_RUN : tpct_pkg::ST_MIN_GO;
      end
      tpct_pkg::ST_SEC_RUN: begin
        if (div_rsp_i.done) state_d = tpct_pkg::ST_MIN_GO;
      end
      tpct_pkg::ST_MIN_GO: state_d = tpct_pkg::ST_MIN_RUN;
      tpct_pkg::ST_MIN_RUN: begin
        if (div_rsp_i.done) begin
          state_d = (len_q == '0) ? tpct_pkg::ST_HOLD : tpct_pkg::ST_PCT_GO;
        end
      end
      tpct_pkg::ST_PCT_GO: state_d = tpct_pkg::ST_PCT_RUN;
      tpct_pkg::ST_PCT_RUN: begin
        if (div_rsp_i.done) state_d = tpct_pkg::ST_HOLD;
      end
      tpct_pkg::ST_HOLD: begin
        if (res_take_i) state_d = tpct_pkg::ST_IDLE;
      end
      default: state_d = tpct_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and divider requests
  always_comb begin
    in_i.ready         = 1'b0;
    res_valid_o        = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.len      = CNT_W'(DIV_W);
    div_req_o.dividend = in_i.data.now_ms - ref_q;
    div_req_o.divisor  = MsDiv;
    case (state_q)
      tpct_pkg::ST_IDLE: begin
        in_i.ready      = 1'b1;
        div_req_o.start = in_i.valid && measure;
      end
      tpct_pkg::ST_MIN_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.len      = CNT_W'(SEC_W);
        div_req_o.dividend = {rem_q, {(DIV_W-SEC_W){1'b0}}};
        div_req_o.divisor  = tpct_pkg::SECS_PER_MIN;
      end
      tpct_pkg::ST_PCT_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.len      = CNT_W'(P100_W);
        div_req_o.dividend = {rem100, {(DIV_W-P100_W){1'b0}}};
        div_req_o.divisor  = DVS_W'(len_q);
      end
      tpct_pkg::ST_HOLD: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Timer state updates
  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    len_d   = len_q;
    rem_d   = rem_q;
    ref_d   = ref_q;
    refv_d  = refv_q;
    now_d   = now_q;
    chime_d = chime_q;
    mins_d  = mins_q;
    ss_d    = ss_q;
    pct_d   = pct_q;
    if (state_q == tpct_pkg::ST_IDLE && accept) begin
      chime_d = tpct_pkg::CHIME_NONE;
      now_d   = in_i.data.now_ms;
      case (mode)
        tpct_pkg::MODE_TICK: begin
          // first tick after a restart only takes the reference
          if (run_q && !refv_q) begin
            ref_d  = in_i.data.now_ms;
            refv_d = 1'b1;
          end
        end
        tpct_pkg::MODE_START: begin
          if (!run_q && rem_q != '0) begin
            run_d   = 1'b1;
            refv_d  = 1'b0;
            chime_d = tpct_pkg::CHIME_CLICK;
          end
        end
        tpct_pkg::MODE_STOP: begin
          if (run_q) begin
            run_d   = 1'b0;
            chime_d = tpct_pkg::CHIME_CLICK;
          end
        end
        tpct_pkg::MODE_RESET: begin
          run_d   = 1'b0;
          rem_d   = len_q;
          refv_d  = 1'b0;
          chime_d = tpct_pkg::CHIME_CLICK;
        end
        tpct_pkg::MODE_SEL_WORK: begin
          phase_d = 1'b0;
          len_d   = work_secs_i;
          rem_d   = work_secs_i;
          run_d   = 1'b0;
          refv_d  = 1'b0;
        end
        tpct_pkg::MODE_SEL_BREAK: begin
          phase_d = 1'b1;
          len_d   = break_secs_i;
          rem_d   = break_secs_i;
          run_d   = 1'b0;
          refv_d  = 1'b0;
        end
        default: ;
      endcase
    end
    // Advance the reference by whole seconds and count down, or switch phase at zero
    if (state_q == tpct_pkg::ST_SEC_RUN && div_rsp_i.done && secs != '0) begin
      ref_d = now_q - TS_W'(div_rsp_i.rem);
      if (secs >= DIV_W'(rem_q)) begin
        phase_d = ~phase_q;
        len_d   = phase_q ? work_secs_i : break_secs_i;
        rem_d   = phase_q ? work_secs_i : break_secs_i;
        run_d   = 1'b0;
        chime_d = tpct_pkg::CHIME_SUCCESS;
      end else begin
        rem_d = rem_q - secs[SEC_W-1:0];
      end
    end
    if (state_q == tpct_pkg::ST_MIN_RUN && div_rsp_i.done) begin
      mins_d = secs[MIN_W-1:0];
      ss_d   = div_rsp_i.rem[SS_W-1:0];
      pct_d  = '0;
    end
    if (state_q == tpct_pkg::ST_PCT_RUN && div_rsp_i.done) begin
      pct_d = secs[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpct_pkg::ST_IDLE;
      phase_q <= 1'b0;
      run_q   <= 1'b0;
      len_q   <= tpct_pkg::WORK_RESET;
      rem_q   <= tpct_pkg::WORK_RESET;
      ref_q   <= '0;
      refv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      run_q   <= run_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      ref_q   <= ref_d;
      refv_q  <= refv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    chime_q <= chime_d;
    mins_q  <= mins_d;
    ss_q    <= ss_d;
    pct_q   <= pct_d;
  end

  assign res_o.phase        = phase_q;
  assign res_o.running      = run_q;
  assign res_o.minutes_left = mins_q;
  assign res_o.seconds_left = ss_q;
  assign res_o.percent_left = pct_q;
  assign res_o.chime        = chime_q;

  // Remaining time never exceeds the loaded phase length
  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= len_q)
    else $error("remaining exceeds phase length");

  // Elapsed time is measured only while running against a valid reference
  a_measure_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpct_pkg::ST_SEC_RUN) |-> (run_q && refv_q))
    else $error("seconds division without a running reference");

  // A finished result never shows more than full percent
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpct_pkg::ST_HOLD) |-> (pct_q <= tpct_pkg::PCT_FULL))
    else $error("percent left out of range");

endmodule

### hdl/two_phase_countdown_timer_top.sv
// Top level of the two-phase countdown timer: config registers, result register.
//
//   channel  dir  payload                                        accepted when
//   in_i     in   mode, now_ms                                   valid && ready
//   out_o    out  phase, running, minutes_left, seconds_left,    valid && ready
//                 percent_left, chime
//   cfg_i    in   index, data (16 bit)                           valid && ready
//
// Each item runs a minutes division and a percentage division; a tick that
// measures elapsed time first runs a seconds division. A zero phase length
// skips the percentage. All use the shared bit-serial divider, one quotient
// bit per cycle: 32 steps for the seconds, 16 for minutes, 23 for the percentage.
// Reset loads both phase lengths and the timer state; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// the sequencer stalls only when that register is still full and out_o is not ready.
module two_phase_countdown_timer_top #(
  parameter int unsigned MS_PER_SECOND = tpct_pkg::MS_PER_SECOND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpct_chan_if.sink   in_i,
  tpct_chan_if.source out_o,
  tpct_chan_if.sink   cfg_i
);

  localparam int unsigned SEC_W = tpct_pkg::SEC_W;

  logic [SEC_W-1:0]    work_q, break_q;
  logic                out_valid_q;
  tpct_pkg::out_item_t out_data_q;
  tpct_pkg::out_item_t res;
  logic                res_valid;
  logic                res_take;
  tpct_pkg::div_req_t  div_req;
  tpct_pkg::div_rsp_t  div_rsp;
  tpct_pkg::cfg_item_t cfg;

  assign cfg         = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  // Hold the phase lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q  <= tpct_pkg::WORK_RESET;
      break_q <= tpct_pkg::BREAK_RESET;
    end else if (cfg_i.valid) begin
      case (tpct_pkg::cfg_idx_e'(cfg.index))
        tpct_pkg::CFG_WORK:  work_q  <= cfg.data;
        tpct_pkg::CFG_BREAK: break_q <= cfg.data;
        default: ;
      endcase
    end
  end

  // Move a finished item into the output register when it is free
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_data_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  tpct_ctrl #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .work_secs_i  (work_q),
    .break_secs_i (break_q),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  tpct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule
